FILE: rtl/core/es2cd_pkg.sv
// shared constants, types and elaboration-time tables for the epoch to date converter
`timescale 1ns / 1ps

package es2cd_pkg;

	localparam int BASE_YEAR_DEF = 1970;

	localparam int SECS_W  = 32;
	localparam int DAYS_W  = 16;
	localparam int REM_W   = 17;
	localparam int YEAR_W  = 12;
	localparam int MONTH_W = 4;
	localparam int DOM_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int DOY_W   = 9;

	// seconds per day = 2^7 * 675, reciprocal of 675 exact for 25-bit dividends
	localparam int            DAY_PRE      = 7;
	localparam int            DAY_SHIFT    = 35;
	localparam logic [25:0]   DAY_RECIP    = 26'd50903317;
	localparam logic [16:0]   SECS_PER_DAY = 17'd86400;

	// seconds per hour = 2^4 * 225
	localparam int            HOUR_PRE       = 4;
	localparam int            HOUR_SHIFT     = 21;
	localparam logic [13:0]   HOUR_RECIP     = 14'd9321;
	localparam logic [11:0]   SECS_PER_HOUR  = 12'd3600;

	// seconds per minute = 2^2 * 15
	localparam int            MIN_PRE       = 2;
	localparam int            MIN_SHIFT     = 14;
	localparam logic [10:0]   MIN_RECIP     = 11'd1093;
	localparam logic [5:0]    SECS_PER_MIN  = 6'd60;

	// year search over offsets from the base year
	localparam int YEAR_SLOTS = 256;
	localparam int IDX_W      = $clog2(YEAR_SLOTS);
	localparam int CUM_W      = 17;

	// stage counts: search steps, day-of-year, month compare, day of month
	localparam int DATE_LAT = IDX_W + 3;
	localparam int TIME_LAT = 5;
	localparam int TIME_PAD = DATE_LAT - TIME_LAT;
	localparam int LAST_STG = 2 + DATE_LAT;

	localparam int MONTHS = 12;
	localparam logic [DOY_W-1:0] MONTH_START [MONTHS] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	typedef logic [YEAR_SLOTS-1:0][CUM_W-1:0] cum_tab_t;
	typedef logic [YEAR_SLOTS-1:0]            leap_tab_t;

	typedef struct packed {
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic [SEC_W-1:0]  second;
	} tod_t;

	function automatic logic is_leap(int y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	// days from the start of the base year to the start of each later year
	function automatic cum_tab_t build_cum(int base);
		cum_tab_t t;
		int       acc;
		acc = 0;
		for (int k = 0; k < YEAR_SLOTS; k++) begin
			t[k] = CUM_W'(acc);
			acc  = acc + (is_leap(base + k) ? 366 : 365);
		end
		return t;
	endfunction

	function automatic leap_tab_t build_leap(int base);
		leap_tab_t t;
		for (int k = 0; k < YEAR_SLOTS; k++) begin
			t[k] = is_leap(base + k);
		end
		return t;
	endfunction

endpackage

FILE: rtl/core/epoch_seconds_to_calendar_date.sv
// top level: unsigned epoch seconds to gregorian date and time of day
//
// input channel: epoch_seconds with in_valid / in_stall; a beat moves when
// in_valid is high and in_stall is low at a rising clk edge.
// output channel: year, month, day_of_month, hour, minute, second with
// out_valid / out_stall, same rule.
// a new beat can enter every cycle while the pipeline is not held by
// out_stall. the depth is set by the year lookup, a binary search over the
// start-of-year table with one index bit per stage (8 stages), plus two input
// and division stages and three stages for day of year, month and day.
// the day, hour and minute splits use reciprocal multipliers, one per stage.
// arst_n clears all valid bits; payload registers are not reset.
// while out_valid is high and out_stall is high the whole pipeline holds and
// in_stall is raised; nothing is dropped or repeated.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_date #(
	parameter int BASE_YEAR = es2cd_pkg::BASE_YEAR_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [es2cd_pkg::SECS_W-1:0]      epoch_seconds,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [es2cd_pkg::YEAR_W-1:0]      year,
	output logic [es2cd_pkg::MONTH_W-1:0]     month,
	output logic [es2cd_pkg::DOM_W-1:0]       day_of_month,
	output logic [es2cd_pkg::HOUR_W-1:0]      hour,
	output logic [es2cd_pkg::MIN_W-1:0]       minute,
	output logic [es2cd_pkg::SEC_W-1:0]       second
);

	localparam int LAST   = es2cd_pkg::LAST_STG;
	localparam int REM_W  = es2cd_pkg::REM_W;
	localparam int DAYS_W = es2cd_pkg::DAYS_W;

	logic            en;
	logic [LAST:1]   vld_s;

	assign en        = !vld_s[LAST] || !out_stall;
	assign in_stall  = !en;
	assign out_valid = vld_s[LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAST-1:1], in_valid};
		end
	end

	// stage 1: input register
	logic [es2cd_pkg::SECS_W-1:0] secs_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			secs_s1 <= epoch_seconds;
		end
	end

	// stage 2: whole days
	localparam int DX_W  = es2cd_pkg::SECS_W - es2cd_pkg::DAY_PRE;
	localparam int DP_W  = DX_W + 26;

	logic [DP_W-1:0]   day_prod;
	logic [DAYS_W-1:0] days_s2;
	logic [REM_W-1:0]  secs_lo_s2;

	assign day_prod = DP_W'(secs_s1[es2cd_pkg::SECS_W-1:es2cd_pkg::DAY_PRE])
		* DP_W'(es2cd_pkg::DAY_RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			days_s2    <= day_prod[es2cd_pkg::DAY_SHIFT +: DAYS_W];
			secs_lo_s2 <= secs_s1[REM_W-1:0];
		end
	end

	// stage 3: seconds of the day
	logic [DAYS_W+REM_W-1:0] day_secs;
	logic [REM_W-1:0]        rem_s3;

	assign day_secs = (DAYS_W+REM_W)'(days_s2) * (DAYS_W+REM_W)'(es2cd_pkg::SECS_PER_DAY);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s3 <= secs_lo_s2 - day_secs[REM_W-1:0];
		end
	end

	// stage 4: hour
	localparam int HP_W = (REM_W - es2cd_pkg::HOUR_PRE) + 14;

	logic [HP_W-1:0]               hour_prod;
	logic [REM_W-1:0]              rem_s4;
	logic [es2cd_pkg::HOUR_W-1:0]  hour_s4;

	assign hour_prod = HP_W'(rem_s3[REM_W-1:es2cd_pkg::HOUR_PRE]) * HP_W'(es2cd_pkg::HOUR_RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s4  <= rem_s3;
			hour_s4 <= hour_prod[es2cd_pkg::HOUR_SHIFT +: es2cd_pkg::HOUR_W];
		end
	end

	// stage 5: seconds of the hour
	logic [16:0]                   hour_secs;
	logic [11:0]                   r2_s5;
	logic [es2cd_pkg::HOUR_W-1:0]  hour_s5;

	assign hour_secs = 17'(hour_s4) * 17'(es2cd_pkg::SECS_PER_HOUR);

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s5   <= rem_s4[11:0] - hour_secs[11:0];
			hour_s5 <= hour_s4;
		end
	end

	// stage 6: minute
	logic [20:0]                   min_prod;
	logic [11:0]                   r2_s6;
	logic [es2cd_pkg::HOUR_W-1:0]  hour_s6;
	logic [es2cd_pkg::MIN_W-1:0]   min_s6;

	assign min_prod = 21'(r2_s5[11:es2cd_pkg::MIN_PRE]) * 21'(es2cd_pkg::MIN_RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s6   <= r2_s5;
			hour_s6 <= hour_s5;
			min_s6  <= min_prod[es2cd_pkg::MIN_SHIFT +: es2cd_pkg::MIN_W];
		end
	end

	// stage 7: second, then delay to line up with the date path
	logic [11:0]       min_secs;
	es2cd_pkg::tod_t   tod_s7;
	es2cd_pkg::tod_t   tod_dly [es2cd_pkg::TIME_PAD];

	assign min_secs = 12'(min_s6) * 12'(es2cd_pkg::SECS_PER_MIN);

	always_ff @(posedge clk) begin
		if (en) begin
			tod_s7.hour   <= hour_s6;
			tod_s7.minute <= min_s6;
			tod_s7.second <= r2_s6[5:0] - min_secs[5:0];
			tod_dly[0]    <= tod_s7;
			for (int k = 1; k < es2cd_pkg::TIME_PAD; k++) begin
				tod_dly[k] <= tod_dly[k-1];
			end
		end
	end

	assign hour   = tod_dly[es2cd_pkg::TIME_PAD-1].hour;
	assign minute = tod_dly[es2cd_pkg::TIME_PAD-1].minute;
	assign second = tod_dly[es2cd_pkg::TIME_PAD-1].second;

	es2cd_date #(
		.BASE_YEAR (BASE_YEAR)
	) u_date (
		.clk          (clk),
		.en           (en),
		.days         (days_s2),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month)
	);

endmodule

FILE: rtl/core/es2cd_date.sv
// day count to year, month and day of month: pipelined table search and month compare
`timescale 1ns / 1ps

module es2cd_date #(
	parameter int BASE_YEAR = es2cd_pkg::BASE_YEAR_DEF
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic [es2cd_pkg::DAYS_W-1:0]       days,
	output logic [es2cd_pkg::YEAR_W-1:0]       year,
	output logic [es2cd_pkg::MONTH_W-1:0]      month,
	output logic [es2cd_pkg::DOM_W-1:0]        day_of_month
);

	localparam int IDX_W  = es2cd_pkg::IDX_W;
	localparam int DAYS_W = es2cd_pkg::DAYS_W;
	localparam int CUM_W  = es2cd_pkg::CUM_W;
	localparam int DOY_W  = es2cd_pkg::DOY_W;
	localparam int MONTHS = es2cd_pkg::MONTHS;

	localparam es2cd_pkg::cum_tab_t  CUM_TAB  = es2cd_pkg::build_cum(BASE_YEAR);
	localparam es2cd_pkg::leap_tab_t LEAP_TAB = es2cd_pkg::build_leap(BASE_YEAR);

	logic [IDX_W-1:0]  idx_s  [IDX_W];
	logic [DAYS_W-1:0] days_s [IDX_W];

	// one index bit per stage, msb first
	for (genvar j = 0; j < IDX_W; j++) begin : g_srch
		logic [IDX_W-1:0]  idx_in;
		logic [IDX_W-1:0]  idx_try;
		logic [DAYS_W-1:0] days_in;

		if (j == 0) begin : g_first
			assign idx_in  = '0;
			assign days_in = days;
		end else begin : g_next
			assign idx_in  = idx_s[j-1];
			assign days_in = days_s[j-1];
		end

		assign idx_try = idx_in | (IDX_W'(1) << (IDX_W - 1 - j));

		always_ff @(posedge clk) begin
			if (en) begin
				days_s[j] <= days_in;
				idx_s[j]  <= (CUM_W'(days_in) >= CUM_TAB[idx_try]) ? idx_try : idx_in;
			end
		end
	end

	logic [CUM_W-1:0] doy_full;
	logic [DOY_W-1:0] doy_s1;
	logic             leap_s1;
	logic [es2cd_pkg::YEAR_W-1:0] year_s1;

	assign doy_full = CUM_W'(days_s[IDX_W-1]) - CUM_TAB[idx_s[IDX_W-1]];

	always_ff @(posedge clk) begin
		if (en) begin
			doy_s1  <= doy_full[DOY_W-1:0];
			leap_s1 <= LEAP_TAB[idx_s[IDX_W-1]];
			year_s1 <= es2cd_pkg::YEAR_W'(BASE_YEAR) + es2cd_pkg::YEAR_W'(idx_s[IDX_W-1]);
		end
	end

	// month = 1 + number of later month starts already passed
	logic [es2cd_pkg::MONTH_W-1:0] ge_cnt;

	always_comb begin
		ge_cnt = '0;
		for (int m = 1; m < MONTHS; m++) begin
			ge_cnt = ge_cnt + es2cd_pkg::MONTH_W'(doy_s1 >= (es2cd_pkg::MONTH_START[m]
				+ DOY_W'(leap_s1 && (m >= 2))));
		end
	end

	logic [DOY_W-1:0]               doy_s2;
	logic                           leap_s2;
	logic [es2cd_pkg::YEAR_W-1:0]   year_s2;
	logic [es2cd_pkg::MONTH_W-1:0]  month_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			doy_s2   <= doy_s1;
			leap_s2  <= leap_s1;
			year_s2  <= year_s1;
			month_s2 <= es2cd_pkg::MONTH_W'(1) + ge_cnt;
		end
	end

	logic [es2cd_pkg::MONTH_W-1:0] msel;
	logic [DOY_W-1:0]              mstart;
	logic [DOY_W-1:0]              dom_full;

	assign msel     = month_s2 - es2cd_pkg::MONTH_W'(1);
	assign mstart   = es2cd_pkg::MONTH_START[msel]
		+ DOY_W'(leap_s2 && (msel >= es2cd_pkg::MONTH_W'(2)));
	assign dom_full = doy_s2 - mstart + DOY_W'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			year         <= year_s2;
			month        <= month_s2;
			day_of_month <= dom_full[es2cd_pkg::DOM_W-1:0];
		end
	end

endmodule
